@@ sv/tjp_pkg.sv @@
// Shared types, constants and a helper function of the trapezoid joint profile block.
`timescale 1ns / 1ps
package tjp_pkg;

  localparam int unsigned NJ            = 7;
  localparam int unsigned POS_W         = 20;
  localparam int unsigned JOINTS_DEF    = 7;
  localparam int unsigned POS_FRAC_DEF  = 16;
  localparam int unsigned ONE_Q16       = 65536;
  localparam int unsigned BLEND_MAX     = 32768;
  localparam int unsigned DIV_STEPS     = 24;
  localparam int unsigned MIN_ACT_COUNT = 6;
  localparam int unsigned IN_DATA_W     = 144;
  localparam int unsigned OUT_DATA_W    = 160;
  localparam int unsigned CFG_W         = 19;

  localparam logic [1:0] REG_MOTION_STEPS   = 2'd0;
  localparam logic [1:0] REG_BLEND_FRACTION = 2'd1;
  localparam logic [1:0] REG_DELTA_SCALE    = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ACT_MUL,
    OP_ACT_UPD,
    OP_MUL_D,
    OP_DIV_A,
    OP_DIV_STEP,
    OP_SHAPE,
    OP_DIV_B,
    OP_ALPHA,
    OP_POS_MUL,
    OP_POS_ADD,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    SEG_LO,
    SEG_HI,
    SEG_MID
  } seg_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] jnt;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
    logic moving;
  } stat_t;

  // Ready pose in fixed point, rounded to nearest and saturated.
  function automatic logic signed [POS_W-1:0] ready_pose(int unsigned idx, int unsigned frac);
    longint mrad;
    longint mag;
    longint q;
    longint v;
    begin
      case (idx)
        1:       mrad = -785;
        3:       mrad = -2356;
        5:       mrad = 1571;
        6:       mrad = 785;
        default: mrad = 0;
      endcase
      mag = (mrad < 0) ? -mrad : mrad;
      q   = ((mag <<< frac) + 500) / 1000;
      v   = (mrad < 0) ? -q : q;
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      ready_pose = POS_W'(v);
    end
  endfunction

endpackage

@@ sv/trapezoid_joint_profile_top.sv @@
// Top level of the seven-joint trapezoidal trajectory generator.
`timescale 1ns / 1ps
// This block turns action requests into smooth joint motions. An action request (tuser 0)
// with at least six valid deltas moves the goal pose by delta times delta_scale per joint,
// saturated to +-8 rad, and makes the old goal the start pose; it gives no result.
// Each tick request (tuser 1) while a motion runs gives one trajectory point k = 0..N,
// with the last point flagged on tlast; a tick while idle is dropped. A tick waits
// before its point enters the output register while that register still holds an
// unread point. Two 48-bit divisions in a shared radix-4 restoring divider dominate
// (24 divide steps each), followed by seven multiply-add steps on the single shared
// multiplier. Requests are
// taken one at a time; a finished point waits in the output register, so the next
// request is accepted while it is still unread. Configuration writes are taken at any
// edge with cfg_we_i high and must only happen while idle.
module trapezoid_joint_profile_top #(
  parameter int unsigned JOINTS        = tjp_pkg::JOINTS_DEF,
  parameter int unsigned POS_FRAC_BITS = tjp_pkg::POS_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // delta_count [2:0], delta_a..delta_g 20 bits each from bit 3 up, zero pad to 144
  input  logic [tjp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func: 0 action, 1 tick
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // point_index [15:0], pos_a..pos_g 20 bits each from bit 16 up, zero pad to 160
  output logic [tjp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // last_point
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [tjp_pkg::CFG_W-1:0]       cfg_data_i
);

  tjp_pkg::cmd_t  cmd;
  tjp_pkg::stat_t stat;

  // The sequencer only needs the request kind and the delta count.
  tjp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_count_i (s_axis_tdata[2:0]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tjp_dp #(
    .JOINTS        (JOINTS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ sv/tjp_ctrl.sv @@
// Sequencer that steps the datapath through actions and trajectory points.
`timescale 1ns / 1ps
module tjp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_func_i,
  input  logic [2:0]    in_count_i,
  output logic          in_ready_o,
  input  tjp_pkg::stat_t stat_i,
  output tjp_pkg::cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_ACT_MUL  = 13'b0000000000010,
    S_ACT_UPD  = 13'b0000000000100,
    S_MUL_D    = 13'b0000000001000,
    S_DIV_A    = 13'b0000000010000,
    S_DIV_RUN1 = 13'b0000000100000,
    S_SHAPE    = 13'b0000001000000,
    S_DIV_B    = 13'b0000010000000,
    S_DIV_RUN2 = 13'b0000100000000,
    S_ALPHA    = 13'b0001000000000,
    S_POS_MUL  = 13'b0010000000000,
    S_POS_ADD  = 13'b0100000000000,
    S_EMIT     = 13'b1000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] jnt_q, jnt_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    jnt_d      = jnt_q;
    cmd_o.op   = tjp_pkg::OP_NONE;
    cmd_o.jnt  = jnt_q;
    case (state_q)
      S_IDLE: begin
        jnt_d = '0;
        if (accept) begin
          cmd_o.op = tjp_pkg::OP_LATCH;
          if (!in_func_i) begin
            if (in_count_i >= 3'(tjp_pkg::MIN_ACT_COUNT)) state_d = S_ACT_MUL;
          end else if (stat_i.moving) begin
            state_d = S_MUL_D;
          end
        end
      end
      S_ACT_MUL: begin
        cmd_o.op = tjp_pkg::OP_ACT_MUL;
        state_d  = S_ACT_UPD;
      end
      S_ACT_UPD: begin
        cmd_o.op = tjp_pkg::OP_ACT_UPD;
        if (jnt_q == 3'(tjp_pkg::NJ - 1)) begin
          state_d = S_IDLE;
        end else begin
          jnt_d   = jnt_q + 3'd1;
          state_d = S_ACT_MUL;
        end
      end
      S_MUL_D: begin
        cmd_o.op = tjp_pkg::OP_MUL_D;
        state_d  = S_DIV_A;
      end
      S_DIV_A: begin
        cmd_o.op = tjp_pkg::OP_DIV_A;
        state_d  = S_DIV_RUN1;
      end
      S_DIV_RUN1: begin
        if (stat_i.div_done) state_d = S_SHAPE;
        else cmd_o.op = tjp_pkg::OP_DIV_STEP;
      end
      S_SHAPE: begin
        cmd_o.op = tjp_pkg::OP_SHAPE;
        state_d  = S_DIV_B;
      end
      S_DIV_B: begin
        cmd_o.op = tjp_pkg::OP_DIV_B;
        state_d  = S_DIV_RUN2;
      end
      S_DIV_RUN2: begin
        if (stat_i.div_done) state_d = S_ALPHA;
        else cmd_o.op = tjp_pkg::OP_DIV_STEP;
      end
      S_ALPHA: begin
        cmd_o.op = tjp_pkg::OP_ALPHA;
        jnt_d    = '0;
        state_d  = S_POS_MUL;
      end
      S_POS_MUL: begin
        cmd_o.op = tjp_pkg::OP_POS_MUL;
        state_d  = S_POS_ADD;
      end
      S_POS_ADD: begin
        cmd_o.op = tjp_pkg::OP_POS_ADD;
        if (jnt_q == 3'(tjp_pkg::NJ - 1)) begin
          state_d = S_EMIT;
        end else begin
          jnt_d   = jnt_q + 3'd1;
          state_d = S_POS_MUL;
        end
      end
      S_EMIT: begin
        if (!stat_i.out_full) begin
          cmd_o.op = tjp_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      jnt_q   <= '0;
    end else begin
      state_q <= state_d;
      jnt_q   <= jnt_d;
    end
  end

endmodule

@@ sv/tjp_dp.sv @@
// Datapath: poses, shared multiplier, two-bit-per-cycle divider and output register.
`timescale 1ns / 1ps
module tjp_dp #(
  parameter int unsigned JOINTS        = tjp_pkg::JOINTS_DEF,
  parameter int unsigned POS_FRAC_BITS = tjp_pkg::POS_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tjp_pkg::cmd_t                   cmd_i,
  output tjp_pkg::stat_t                  stat_o,
  input  logic [tjp_pkg::IN_DATA_W-1:0]   in_data_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [tjp_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tjp_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic                            out_last_o
);

  localparam int unsigned ShAct = 32 - POS_FRAC_BITS;
  localparam int unsigned PW    = tjp_pkg::POS_W;

  // configuration
  logic [15:0] steps_q, blend_q;
  logic [18:0] scale_q;

  // motion state
  logic signed [PW-1:0] start_q [tjp_pkg::NJ];
  logic signed [PW-1:0] goal_q  [tjp_pkg::NJ];
  logic signed [PW-1:0] pos_q   [tjp_pkg::NJ];
  logic signed [PW-1:0] dlt_q   [tjp_pkg::NJ];
  logic [2:0]           cnt_q;
  logic [15:0]          step_q;
  logic                 moving_q;

  // profile working registers
  logic [15:0]          n_q;
  logic [15:0]          b_q;
  logic                 last_q;
  logic [30:0]          d_q;
  logic [16:0]          a_q;
  tjp_pkg::seg_e        seg_q;
  logic [16:0]          al_q;
  logic signed [40:0]   prod_q;

  // divider
  logic [30:0]          dv_rem_q;
  logic [47:0]          dv_quo_q;
  logic [30:0]          dv_den_q;
  logic [4:0]           dv_cnt_q;

  // output register
  logic                           out_valid_q;
  logic [tjp_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                           out_last_q;

  logic [2:0]  jnt;
  logic [15:0] n_c, b_c;
  logic [2:0]  lim;

  assign jnt = cmd_i.jnt;
  assign n_c = (steps_q == 16'd0) ? 16'd1 : steps_q;
  assign b_c = (blend_q > 16'(tjp_pkg::BLEND_MAX)) ? 16'(tjp_pkg::BLEND_MAX) : blend_q;
  assign lim = (cnt_q < 3'(JOINTS)) ? cnt_q : 3'(JOINTS);

  // shared multiplier
  logic signed [20:0] mul_a;
  logic [18:0]        mul_b;
  logic signed [40:0] mul_p;

  // profile shaping
  logic [16:0] a_c, u_c, x_c;
  logic        lo_c, hi_c;

  assign a_c  = last_q ? 17'(tjp_pkg::ONE_Q16) : dv_quo_q[16:0];
  assign lo_c = a_c < {1'b0, b_q};
  assign hi_c = a_c > (17'(tjp_pkg::ONE_Q16) - {1'b0, b_q});
  assign u_c  = 17'(tjp_pkg::ONE_Q16) - a_c;
  assign x_c  = lo_c ? a_c : u_c;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      tjp_pkg::OP_ACT_MUL: begin
        mul_a = 21'(dlt_q[jnt]);
        mul_b = scale_q;
      end
      tjp_pkg::OP_MUL_D: begin
        mul_a = {5'b0, b_c};
        mul_b = {2'b0, 17'(tjp_pkg::ONE_Q16) - {1'b0, b_c}};
      end
      tjp_pkg::OP_SHAPE: begin
        mul_a = {4'b0, x_c};
        mul_b = {2'b0, x_c};
      end
      tjp_pkg::OP_POS_MUL: begin
        mul_a = 21'(goal_q[jnt]) - 21'(start_q[jnt]);
        mul_b = {2'b0, al_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // goal update: product scaled down with truncation toward zero, then saturated
  logic signed [40:0] act_sh;
  logic               act_up;
  logic signed [41:0] goal_sum;
  logic signed [PW-1:0] goal_new;

  assign act_sh   = prod_q >>> ShAct;
  assign act_up   = prod_q[40] && ((prod_q & ((41'(1) << ShAct) - 41'(1))) != '0);
  assign goal_sum = 42'(goal_q[jnt]) + 42'(act_sh) + 42'(act_up);

  always_comb begin
    if (goal_sum > 42'sd524287) goal_new = 20'sd524287;
    else if (goal_sum < -42'sd524288) goal_new = -20'sd524288;
    else goal_new = goal_sum[PW-1:0];
  end

  // joint interpolation
  logic signed [40:0] pos_sh;
  logic               pos_up;
  logic signed [41:0] pos_sum;

  assign pos_sh  = prod_q >>> 16;
  assign pos_up  = prod_q[40] && (prod_q[15:0] != 16'd0);
  assign pos_sum = 42'(start_q[jnt]) + 42'(pos_sh) + 42'(pos_up);

  // divider: two restoring steps per cycle
  logic [31:0] r1s, r2s, den32;
  logic        ge1, ge2;
  logic [30:0] r1, r2;

  assign den32 = {1'b0, dv_den_q};
  assign r1s   = {dv_rem_q, dv_quo_q[47]};
  assign ge1   = r1s >= den32;
  assign r1    = ge1 ? 31'(r1s - den32) : r1s[30:0];
  assign r2s   = {r1, dv_quo_q[46]};
  assign ge2   = r2s >= den32;
  assign r2    = ge2 ? 31'(r2s - den32) : r2s[30:0];

  // alpha from the second quotient
  logic        t_big;
  logic [16:0] al_c;
  logic [16:0] mid_num;

  assign t_big   = (dv_quo_q[47:17] != '0) || (dv_quo_q[16] && (dv_quo_q[15:0] != 16'd0));
  assign mid_num = a_q - {2'b0, b_q[15:1]};

  always_comb begin
    if (seg_q == tjp_pkg::SEG_HI) begin
      al_c = t_big ? 17'd0 : 17'(tjp_pkg::ONE_Q16) - dv_quo_q[16:0];
    end else begin
      al_c = t_big ? 17'(tjp_pkg::ONE_Q16) : dv_quo_q[16:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= 16'd200;
      blend_q <= 16'd13107;
      scale_q <= 19'd19661;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tjp_pkg::REG_MOTION_STEPS:   steps_q <= cfg_data_i[15:0];
        tjp_pkg::REG_BLEND_FRACTION: blend_q <= cfg_data_i[15:0];
        tjp_pkg::REG_DELTA_SCALE:    scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // poses and motion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tjp_pkg::NJ; i++) begin
        start_q[i] <= tjp_pkg::ready_pose(i, POS_FRAC_BITS);
        goal_q[i]  <= tjp_pkg::ready_pose(i, POS_FRAC_BITS);
      end
      step_q   <= '0;
      moving_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        tjp_pkg::OP_ACT_UPD: begin
          start_q[jnt] <= goal_q[jnt];
          if (jnt < lim) goal_q[jnt] <= goal_new;
          if (jnt == 3'(tjp_pkg::NJ - 1)) begin
            step_q   <= '0;
            moving_q <= 1'b1;
          end
        end
        tjp_pkg::OP_EMIT: begin
          if (last_q) moving_q <= 1'b0;
          else step_q <= step_q + 16'd1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tjp_pkg::OP_LATCH: begin
        cnt_q <= in_data_i[2:0];
        for (int i = 0; i < tjp_pkg::NJ; i++) begin
          dlt_q[i] <= in_data_i[3 + PW*i +: PW];
        end
      end
      tjp_pkg::OP_ACT_MUL: prod_q <= mul_p;
      tjp_pkg::OP_MUL_D: begin
        n_q    <= n_c;
        b_q    <= b_c;
        last_q <= step_q >= n_c;
        d_q    <= mul_p[30:0];
      end
      tjp_pkg::OP_DIV_A: begin
        dv_rem_q <= '0;
        dv_quo_q <= {16'b0, step_q, 16'b0};
        dv_den_q <= {15'b0, n_q};
      end
      tjp_pkg::OP_DIV_STEP: begin
        dv_rem_q <= r2;
        dv_quo_q <= {dv_quo_q[45:0], ge1, ge2};
      end
      tjp_pkg::OP_SHAPE: begin
        a_q    <= a_c;
        prod_q <= mul_p;
        if (lo_c) seg_q <= tjp_pkg::SEG_LO;
        else if (hi_c) seg_q <= tjp_pkg::SEG_HI;
        else seg_q <= tjp_pkg::SEG_MID;
      end
      tjp_pkg::OP_DIV_B: begin
        dv_rem_q <= '0;
        if (seg_q == tjp_pkg::SEG_MID) begin
          dv_quo_q <= {15'b0, mid_num, 16'b0};
          dv_den_q <= 31'(17'(tjp_pkg::ONE_Q16) - {1'b0, b_q});
        end else begin
          dv_quo_q <= {3'b0, prod_q[29:0], 15'b0};
          dv_den_q <= d_q;
        end
      end
      tjp_pkg::OP_ALPHA:   al_q   <= al_c;
      tjp_pkg::OP_POS_MUL: prod_q <= mul_p;
      tjp_pkg::OP_POS_ADD: begin
        pos_q[jnt] <= (jnt < 3'(JOINTS)) ? pos_sum[PW-1:0] : '0;
      end
      default: ;
    endcase
  end

  // divider step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_cnt_q <= '0;
    end else if (cmd_i.op == tjp_pkg::OP_DIV_A || cmd_i.op == tjp_pkg::OP_DIV_B) begin
      dv_cnt_q <= 5'(tjp_pkg::DIV_STEPS);
    end else if (cmd_i.op == tjp_pkg::OP_DIV_STEP && dv_cnt_q != '0) begin
      dv_cnt_q <= dv_cnt_q - 5'd1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == tjp_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tjp_pkg::OP_EMIT) begin
      out_last_q        <= last_q;
      out_data_q[15:0]  <= step_q;
      for (int i = 0; i < tjp_pkg::NJ; i++) begin
        out_data_q[16 + PW*i +: PW] <= pos_q[i];
      end
      out_data_q[tjp_pkg::OUT_DATA_W-1:16 + PW*tjp_pkg::NJ] <= '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_last_o      = out_last_q;
  assign stat_o.div_done = (dv_cnt_q == '0);
  assign stat_o.out_full = out_valid_q && !out_ready_i;
  assign stat_o.moving   = moving_q;

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == tjp_pkg::OP_POS_MUL) |-> (al_q <= 17'(tjp_pkg::ONE_Q16)))
    else $error("alpha above one");

  a_blend_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == tjp_pkg::OP_SHAPE) |-> (b_q <= 16'(tjp_pkg::BLEND_MAX)))
    else $error("blend share not limited");

  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == tjp_pkg::OP_EMIT && last_q) |=> !moving_q)
    else $error("motion continues after last point");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_cnt_q <= 5'(tjp_pkg::DIV_STEPS))
    else $error("divider step count out of range");

endmodule
